FILE: rtl/da4_pkg.sv
package da4_pkg;

  localparam int CHANNELS  = 4;
  localparam int REG_BYTES = 12;

  localparam logic [31:0] FIFO_A = 32'h0400_00A0;
  localparam logic [31:0] FIFO_B = 32'h0400_00A4;

  localparam logic [16:0] FIFO_COUNT    = 17'd4;
  localparam logic [16:0] COUNT_DEFAULT = 17'h0_4000;
  localparam logic [16:0] COUNT_MAX     = 17'h1_0000;
  localparam int          BIG_COUNT_CH  = 3;

  localparam int EN_BIT = 31;

  localparam logic [1:0] REGSEL_SRC  = 2'd0;
  localparam logic [1:0] REGSEL_DST  = 2'd1;
  localparam logic [1:0] REGSEL_CTRL = 2'd2;
  localparam logic [3:0] CTRL_TOP_BYTE = 4'd11;

  localparam logic [1:0] STEP_INC    = 2'd0;
  localparam logic [1:0] STEP_DEC    = 2'd1;
  localparam logic [1:0] STEP_FIXED  = 2'd2;
  localparam logic [1:0] STEP_RELOAD = 2'd3;

  localparam logic [1:0] TIM_NOW     = 2'd0;
  localparam logic [1:0] TIM_VBLANK  = 2'd1;
  localparam logic [1:0] TIM_HBLANK  = 2'd2;
  localparam logic [1:0] TIM_SPECIAL = 2'd3;

  typedef enum logic [2:0] {
    OP_WRITE   = 3'd0,
    OP_VBLANK  = 3'd1,
    OP_HBLANK  = 3'd2,
    OP_TRIGGER = 3'd3,
    OP_ADVANCE = 3'd4
  } op_t;

  typedef struct packed {
    logic       irq;
    logic       rpt;
    logic       word;
    logic [1:0] sstep;
    logic [1:0] dstep;
  } mode_t;

  function automatic logic [31:0] put_byte(logic [31:0] w, logic [1:0] lane, logic [7:0] b);
    logic [31:0] r;
    r = w;
    r[8*lane +: 8] = b;
    return r;
  endfunction

endpackage

FILE: rtl/four_channel_dma_address_engine.sv
// Channel  Direction  Handshake              Payload
// in       input      in_valid / in_ready    operation, reg_offset, write_byte, channel
// out      output     out_valid / out_ready  transfer_valid, transfer_channel, source_address,
//                                            dest_address, word_transfer, run_done,
//                                            interrupt_mask
// Every item yields one result; the item is held in the input register, then registered into the result register.
// One item is accepted per cycle while the result register is not stalled: the channel state
// updates in the cycle the item moves from the input register into the result register.
// Reset (rst, synchronous) clears all channel registers, counts and run modes.
// A stalled result register holds the input register; the input accepts while either is free.
module four_channel_dma_address_engine (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  operation,
  input  logic [5:0]  reg_offset,
  input  logic [7:0]  write_byte,
  input  logic [1:0]  channel,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        transfer_valid,
  output logic [1:0]  transfer_channel,
  output logic [31:0] source_address,
  output logic [31:0] dest_address,
  output logic        word_transfer,
  output logic        run_done,
  output logic [3:0]  interrupt_mask
);
  import da4_pkg::*;

  logic        pend;
  logic [2:0]  op_q;
  logic [5:0]  off_q;
  logic [7:0]  byte_q;
  logic [1:0]  chan_q;
  logic        adv;

  logic [31:0] source_reg [CHANNELS];
  logic [31:0] dest_reg [CHANNELS];
  logic [31:0] control_reg [CHANNELS];
  logic [31:0] working_source [CHANNELS];
  logic [31:0] working_dest [CHANNELS];
  logic [16:0] units_left [CHANNELS];
  mode_t       run_mode [CHANNELS];

  logic [31:0] source_reg_next [CHANNELS];
  logic [31:0] dest_reg_next [CHANNELS];
  logic [31:0] control_reg_next [CHANNELS];
  logic [31:0] working_source_next [CHANNELS];
  logic [31:0] working_dest_next [CHANNELS];
  logic [16:0] units_left_next [CHANNELS];
  mode_t       run_mode_next [CHANNELS];

  logic [CHANNELS-1:0] grant;
  logic                found;
  logic [CHANNELS-1:0] hit;
  logic [3:0]          byte_sel [CHANNELS];
  logic [31:0]         src_w [CHANNELS];
  logic [31:0]         dst_w [CHANNELS];
  logic [31:0]         cw_w [CHANNELS];
  logic [CHANNELS-1:0] fifo;
  logic [CHANNELS-1:0] idle;
  logic [16:0]         start_units [CHANNELS];
  mode_t               start_mode [CHANNELS];
  logic [31:0]         unit_step [CHANNELS];
  logic [1:0]          blank_tim;

  logic        res_valid;
  logic [1:0]  res_ch;
  logic [31:0] res_src;
  logic [31:0] res_dst;
  logic        res_word;
  logic        res_done;
  logic [3:0]  res_irq;

  assign adv      = !out_valid || out_ready;
  assign in_ready = !pend || adv;

  always_comb begin
    grant = '0;
    found = 1'b0;
    for (int i = 0; i < CHANNELS; i++) begin
      if (!found && units_left[i] != '0) begin
        grant[i] = 1'b1;
        found    = 1'b1;
      end
    end

    blank_tim = (op_q == OP_VBLANK) ? TIM_VBLANK : TIM_HBLANK;

    res_valid = 1'b0;
    res_ch    = '0;
    res_src   = '0;
    res_dst   = '0;
    res_word  = 1'b0;
    res_done  = 1'b0;
    res_irq   = '0;

    for (int i = 0; i < CHANNELS; i++) begin
      hit[i] = (op_q == OP_WRITE) && (off_q >= 6'(REG_BYTES * i)) &&
               (off_q < 6'(REG_BYTES * (i + 1)));
      byte_sel[i] = 4'(off_q - 6'(REG_BYTES * i));
      src_w[i] = source_reg[i];
      dst_w[i] = dest_reg[i];
      cw_w[i]  = control_reg[i];
      if (hit[i]) begin
        case (byte_sel[i][3:2])
          REGSEL_SRC:  src_w[i] = put_byte(source_reg[i], byte_sel[i][1:0], byte_q);
          REGSEL_DST:  dst_w[i] = put_byte(dest_reg[i], byte_sel[i][1:0], byte_q);
          REGSEL_CTRL: cw_w[i]  = put_byte(control_reg[i], byte_sel[i][1:0], byte_q);
          default: ;
        endcase
      end

      idle[i] = units_left[i] == '0;
      fifo[i] = (cw_w[i][29:28] == TIM_SPECIAL) && (dst_w[i] == FIFO_A || dst_w[i] == FIFO_B);
      if (fifo[i]) begin
        start_units[i] = FIFO_COUNT;
      end else if (cw_w[i][15:0] != '0) begin
        start_units[i] = {1'b0, cw_w[i][15:0]};
      end else if (i == BIG_COUNT_CH) begin
        start_units[i] = COUNT_MAX;
      end else begin
        start_units[i] = COUNT_DEFAULT;
      end
      start_mode[i].dstep = fifo[i] ? STEP_FIXED : cw_w[i][22:21];
      start_mode[i].sstep = cw_w[i][24:23];
      start_mode[i].rpt   = cw_w[i][25];
      start_mode[i].word  = cw_w[i][26];
      start_mode[i].irq   = cw_w[i][30];

      unit_step[i] = run_mode[i].word ? 32'd4 : 32'd2;

      source_reg_next[i]     = src_w[i];
      dest_reg_next[i]       = dst_w[i];
      control_reg_next[i]    = cw_w[i];
      working_source_next[i] = working_source[i];
      working_dest_next[i]   = working_dest[i];
      units_left_next[i]     = units_left[i];
      run_mode_next[i]       = run_mode[i];

      case (op_q)
        OP_WRITE: begin
          if (hit[i] && byte_sel[i] == CTRL_TOP_BYTE && cw_w[i][EN_BIT] && idle[i]) begin
            working_source_next[i] = src_w[i];
            working_dest_next[i]   = dst_w[i];
            if (cw_w[i][29:28] == TIM_NOW) begin
              units_left_next[i] = start_units[i];
              run_mode_next[i]   = start_mode[i];
            end
          end
        end
        OP_VBLANK, OP_HBLANK: begin
          if (cw_w[i][EN_BIT] && cw_w[i][29:28] == blank_tim && idle[i]) begin
            if (cw_w[i][22:21] == STEP_RELOAD) working_dest_next[i] = dst_w[i];
            units_left_next[i] = start_units[i];
            run_mode_next[i]   = start_mode[i];
          end
        end
        OP_TRIGGER: begin
          if (chan_q == 2'(i) && cw_w[i][EN_BIT] && idle[i]) begin
            units_left_next[i] = start_units[i];
            run_mode_next[i]   = start_mode[i];
          end
        end
        OP_ADVANCE: begin
          if (grant[i]) begin
            res_valid = 1'b1;
            res_ch    = 2'(i);
            res_src   = working_source[i];
            res_dst   = working_dest[i];
            res_word  = run_mode[i].word;
            if (run_mode[i].dstep == STEP_INC || run_mode[i].dstep == STEP_RELOAD) begin
              working_dest_next[i] = working_dest[i] + unit_step[i];
            end else if (run_mode[i].dstep == STEP_DEC) begin
              working_dest_next[i] = working_dest[i] - unit_step[i];
            end
            if (run_mode[i].sstep == STEP_INC) begin
              working_source_next[i] = working_source[i] + unit_step[i];
            end else if (run_mode[i].sstep == STEP_DEC) begin
              working_source_next[i] = working_source[i] - unit_step[i];
            end
            units_left_next[i] = units_left[i] - 17'd1;
            if (units_left[i] == 17'd1) begin
              res_done = 1'b1;
              if (run_mode[i].dstep == STEP_RELOAD) working_dest_next[i] = dest_reg[i];
              if (!run_mode[i].rpt) control_reg_next[i][EN_BIT] = 1'b0;
              if (run_mode[i].irq) res_irq = 4'b0001 << i;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend      <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        source_reg[i]     <= '0;
        dest_reg[i]       <= '0;
        control_reg[i]    <= '0;
        working_source[i] <= '0;
        working_dest[i]   <= '0;
        units_left[i]     <= '0;
        run_mode[i]       <= '0;
      end
    end else begin
      if (in_valid && in_ready) begin
        pend   <= 1'b1;
        op_q   <= operation;
        off_q  <= reg_offset;
        byte_q <= write_byte;
        chan_q <= channel;
      end else if (adv) begin
        pend <= 1'b0;
      end
      if (adv) begin
        out_valid <= pend;
      end
      if (pend && adv) begin
        transfer_valid   <= res_valid;
        transfer_channel <= res_ch;
        source_address   <= res_src;
        dest_address     <= res_dst;
        word_transfer    <= res_word;
        run_done         <= res_done;
        interrupt_mask   <= res_irq;
        for (int i = 0; i < CHANNELS; i++) begin
          source_reg[i]     <= source_reg_next[i];
          dest_reg[i]       <= dest_reg_next[i];
          control_reg[i]    <= control_reg_next[i];
          working_source[i] <= working_source_next[i];
          working_dest[i]   <= working_dest_next[i];
          units_left[i]     <= units_left_next[i];
          run_mode[i]       <= run_mode_next[i];
        end
      end
    end
  end

  a_done_has_transfer: assert property (@(posedge clk) disable iff (rst)
    out_valid && run_done |-> transfer_valid)
    else $error("run end without transfer");

  a_irq_on_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && interrupt_mask != 4'd0 |-> run_done && $onehot(interrupt_mask))
    else $error("interrupt outside run end");

  a_irq_channel: assert property (@(posedge clk) disable iff (rst)
    out_valid && interrupt_mask != 4'd0 |-> interrupt_mask == (4'b0001 << transfer_channel))
    else $error("interrupt on wrong channel");

  a_idle_no_result: assert property (@(posedge clk) disable iff (rst)
    !pend && !out_valid |=> !out_valid)
    else $error("result without item");

endmodule

FILE: dv/testbench.sv
module testbench;
  import da4_pkg::*;

  typedef struct packed {
    logic        valid;
    logic [1:0]  chan;
    logic [31:0] src;
    logic [31:0] dst;
    logic        word;
    logic        done;
    logic [3:0]  irq;
  } xfer_t;

  typedef struct packed {
    logic [2:0] op;
    logic [5:0] off;
    logic [7:0] wb;
    logic [1:0] ch;
    logic       idle;
  } row_t;

  localparam logic [2:0] OP_NONE = 3'd7;
  localparam int B_DST      = 4;
  localparam int B_CTL      = 8;
  localparam int B_COUNT_HI = 9;
  localparam int LIMIT      = 3000000;
  localparam int PLAN_LEN   = 26;

  localparam row_t PLAN [PLAN_LEN] = '{
    '{OP_ADVANCE, 6'd0,  8'h00, 2'd0, 1'b1},
    '{OP_NONE,    6'd63, 8'hFF, 2'd3, 1'b1},
    '{OP_WRITE,   6'd63, 8'hFF, 2'd0, 1'b1},
    '{OP_TRIGGER, 6'd0,  8'h00, 2'd2, 1'b1},
    '{OP_WRITE,   6'd0,  8'hFE, 2'd0, 1'b0},
    '{OP_WRITE,   6'd3,  8'hFF, 2'd0, 1'b0},
    '{OP_WRITE,   6'd8,  8'h02, 2'd0, 1'b0},
    '{OP_WRITE,   6'd10, 8'hA0, 2'd0, 1'b0},
    '{OP_WRITE,   6'd11, 8'hC4, 2'd0, 1'b0},
    '{OP_ADVANCE, 6'd0,  8'h00, 2'd0, 1'b0},
    '{OP_TRIGGER, 6'd0,  8'h00, 2'd0, 1'b1},
    '{OP_WRITE,   6'd11, 8'hC4, 2'd0, 1'b0},
    '{OP_ADVANCE, 6'd0,  8'h00, 2'd0, 1'b0},
    '{OP_ADVANCE, 6'd0,  8'h00, 2'd0, 1'b1},
    '{OP_WRITE,   6'd16, 8'hA0, 2'd1, 1'b0},
    '{OP_WRITE,   6'd17, 8'h00, 2'd1, 1'b0},
    '{OP_WRITE,   6'd18, 8'h00, 2'd1, 1'b0},
    '{OP_WRITE,   6'd19, 8'h04, 2'd1, 1'b0},
    '{OP_WRITE,   6'd23, 8'hF0, 2'd1, 1'b0},
    '{OP_HBLANK,  6'd0,  8'h00, 2'd0, 1'b1},
    '{OP_TRIGGER, 6'd0,  8'h00, 2'd1, 1'b0},
    '{OP_ADVANCE, 6'd0,  8'h00, 2'd0, 1'b0},
    '{OP_ADVANCE, 6'd0,  8'h00, 2'd0, 1'b0},
    '{OP_ADVANCE, 6'd0,  8'h00, 2'd0, 1'b0},
    '{OP_ADVANCE, 6'd0,  8'h00, 2'd0, 1'b0},
    '{OP_VBLANK,  6'd0,  8'h00, 2'd0, 1'b0}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic out_ready = 1'b0;
  logic [2:0] operation = '0;
  logic [5:0] reg_offset = '0;
  logic [7:0] write_byte = '0;
  logic [1:0] channel = '0;
  logic in_ready, out_valid, transfer_valid, word_transfer, run_done;
  logic [1:0] transfer_channel;
  logic [31:0] source_address, dest_address;
  logic [3:0] interrupt_mask;

  logic [31:0] src_reg [CHANNELS];
  logic [31:0] dst_reg [CHANNELS];
  logic [31:0] ctl_reg [CHANNELS];
  logic [31:0] cur_src [CHANNELS];
  logic [31:0] cur_dst [CHANNELS];
  logic [16:0] units   [CHANNELS];
  mode_t       run_md  [CHANNELS];

  xfer_t due_transfers [$];
  bit quiet;
  int taken;
  int mismatches;
  int cycles;

  four_channel_dma_address_engine u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .operation(operation), .reg_offset(reg_offset),
    .write_byte(write_byte), .channel(channel),
    .out_valid(out_valid), .out_ready(out_ready),
    .transfer_valid(transfer_valid), .transfer_channel(transfer_channel),
    .source_address(source_address), .dest_address(dest_address),
    .word_transfer(word_transfer), .run_done(run_done),
    .interrupt_mask(interrupt_mask)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void launch_run(int c);
    logic [16:0] cnt;
    logic [1:0] ds;
    logic fifo;
    if (units[c] != 0) return;
    fifo = ctl_reg[c][29:28] == TIM_SPECIAL &&
           (dst_reg[c] == FIFO_A || dst_reg[c] == FIFO_B);
    if (fifo) begin
      cnt = FIFO_COUNT;
      ds = STEP_FIXED;
    end else begin
      cnt = {1'b0, ctl_reg[c][15:0]};
      if (cnt == 0) cnt = (c == BIG_COUNT_CH) ? COUNT_MAX : COUNT_DEFAULT;
      ds = ctl_reg[c][22:21];
    end
    units[c] = cnt;
    run_md[c].dstep = ds;
    run_md[c].sstep = ctl_reg[c][24:23];
    run_md[c].word = ctl_reg[c][26];
    run_md[c].rpt = ctl_reg[c][25];
    run_md[c].irq = ctl_reg[c][30];
  endfunction

  function automatic void blank_start(logic [1:0] tim);
    for (int c = 0; c < CHANNELS; c++) begin
      if (ctl_reg[c][EN_BIT] && ctl_reg[c][29:28] == tim && units[c] == 0) begin
        if (ctl_reg[c][22:21] == STEP_RELOAD) cur_dst[c] = dst_reg[c];
        launch_run(c);
      end
    end
  endfunction

  function automatic void reg_write(logic [5:0] off, logic [7:0] wb);
    int c, b, lane;
    if (off >= REG_BYTES * CHANNELS) return;
    c = off / REG_BYTES;
    b = off % REG_BYTES;
    lane = b % 4;
    case (2'(b / 4))
      REGSEL_SRC: src_reg[c][8*lane +: 8] = wb;
      REGSEL_DST: dst_reg[c][8*lane +: 8] = wb;
      default: ctl_reg[c][8*lane +: 8] = wb;
    endcase
    if (b == CTRL_TOP_BYTE && ctl_reg[c][EN_BIT] && units[c] == 0) begin
      cur_src[c] = src_reg[c];
      cur_dst[c] = dst_reg[c];
      if (ctl_reg[c][29:28] == TIM_NOW) launch_run(c);
    end
  endfunction

  function automatic xfer_t move_unit();
    xfer_t res;
    mode_t md;
    logic [31:0] step;
    int c;
    res = '0;
    c = -1;
    for (int i = CHANNELS - 1; i >= 0; i--)
      if (units[i] != 0) c = i;
    if (c < 0) return res;
    md = run_md[c];
    step = md.word ? 32'd4 : 32'd2;
    res.valid = 1'b1;
    res.chan = 2'(c);
    res.src = cur_src[c];
    res.dst = cur_dst[c];
    res.word = md.word;
    if (md.dstep == STEP_INC || md.dstep == STEP_RELOAD) cur_dst[c] += step;
    else if (md.dstep == STEP_DEC) cur_dst[c] -= step;
    if (md.sstep == STEP_INC) cur_src[c] += step;
    else if (md.sstep == STEP_DEC) cur_src[c] -= step;
    units[c] -= 1;
    if (units[c] == 0) begin
      res.done = 1'b1;
      if (md.dstep == STEP_RELOAD) cur_dst[c] = dst_reg[c];
      if (!md.rpt) ctl_reg[c][EN_BIT] = 1'b0;
      if (md.irq) res.irq[c] = 1'b1;
    end
    return res;
  endfunction

  function automatic xfer_t predict_transfer(logic [2:0] op, logic [5:0] off,
                                             logic [7:0] wb, logic [1:0] ch);
    xfer_t res;
    res = '0;
    case (op)
      OP_WRITE: reg_write(off, wb);
      OP_VBLANK: blank_start(TIM_VBLANK);
      OP_HBLANK: blank_start(TIM_HBLANK);
      OP_TRIGGER: if (ch < CHANNELS && ctl_reg[ch][EN_BIT]) launch_run(int'(ch));
      OP_ADVANCE: res = move_unit();
      default: ;
    endcase
    return res;
  endfunction

  function automatic bit any_running();
    bit r;
    r = 1'b0;
    for (int c = 0; c < CHANNELS; c++)
      if (units[c] != 0) r = 1'b1;
    return r;
  endfunction

  task automatic send(logic [2:0] op, logic [5:0] off, logic [7:0] wb, logic [1:0] ch,
                      bit idle_typed = 1'b0);
    int gap;
    xfer_t want;
    gap = quiet ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    reg_offset <= off;
    write_byte <= wb;
    channel <= ch;
    do @(posedge clk); while (!in_ready);
    want = predict_transfer(op, off, wb, ch);
    if (idle_typed) want = '0;
    due_transfers.push_back(want);
    taken++;
  endtask

  task automatic step_unit();
    send(OP_ADVANCE, 6'($urandom), 8'($urandom), 2'($urandom));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (due_transfers.size() != 0);
  endtask

  task automatic send_noise();
    logic [2:0] op;
    logic [5:0] off;
    logic [7:0] wb;
    op = 3'($urandom_range(0, 7));
    off = 6'($urandom_range(0, 63));
    wb = 8'($urandom);
    // keep counts short and nonzero
    if (op == OP_WRITE && off < REG_BYTES * CHANNELS) begin
      if (off % REG_BYTES == B_CTL) wb = 8'($urandom_range(1, 15));
      else if (off % REG_BYTES == B_COUNT_HI) wb = 8'd0;
    end
    send(op, off, wb, 2'($urandom));
  endtask

  task automatic program_channel(int c);
    logic [31:0] s, d, k;
    logic [2:0] ev;
    logic [1:0] ch;
    int n;
    s = $urandom;
    k = $urandom;
    case ($urandom_range(0, 5))
      0: d = FIFO_A;
      1: d = FIFO_B;
      default: d = $urandom;
    endcase
    k[15:0] = ($urandom_range(0, 19) == 0) ? 16'($urandom_range(7, 40))
                                           : 16'($urandom_range(1, 6));
    k[EN_BIT] = ($urandom_range(0, 7) != 0);
    for (int b = 0; b < 4; b++)
      send(OP_WRITE, 6'(c * REG_BYTES + b), s[8*b +: 8], 2'($urandom));
    for (int b = 0; b < 4; b++)
      send(OP_WRITE, 6'(c * REG_BYTES + B_DST + b), d[8*b +: 8], 2'($urandom));
    for (int b = 0; b < 4; b++)
      send(OP_WRITE, 6'(c * REG_BYTES + B_CTL + b), k[8*b +: 8], 2'($urandom));
    case (k[29:28])
      TIM_VBLANK: ev = OP_VBLANK;
      TIM_HBLANK: ev = OP_HBLANK;
      TIM_SPECIAL: ev = OP_TRIGGER;
      default: ev = OP_ADVANCE;
    endcase
    if ($urandom_range(0, 5) == 0) ev = 3'($urandom_range(int'(OP_VBLANK), int'(OP_TRIGGER)));
    ch = ($urandom_range(0, 7) == 0) ? 2'($urandom) : 2'(c);
    if (ev != OP_ADVANCE) send(ev, 6'($urandom), 8'($urandom), ch);
    n = $urandom_range(0, 8);
    repeat (n) step_unit();
  endtask

  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s expected %h got %h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin : result_check
    xfer_t want, got;
    if (!rst && out_valid && out_ready) begin
      got = {transfer_valid, transfer_channel, source_address, dest_address,
             word_transfer, run_done, interrupt_mask};
      if (due_transfers.size() == 0) begin
        mismatches++;
        $display("%0t: transfer expected none got %h", $time, got);
      end else begin
        want = due_transfers.pop_front();
        compare_field("transfer_valid", 32'(want.valid), 32'(got.valid));
        compare_field("transfer_channel", 32'(want.chan), 32'(got.chan));
        compare_field("source_address", want.src, got.src);
        compare_field("dest_address", want.dst, got.dst);
        compare_field("word_transfer", 32'(want.word), 32'(got.word));
        compare_field("run_done", 32'(want.done), 32'(got.done));
        compare_field("interrupt_mask", 32'(want.irq), 32'(got.irq));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  initial begin : result_sink
    int stall;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 12);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin : stimulus
    int first;
    for (int c = 0; c < CHANNELS; c++) begin
      src_reg[c] = '0;
      dst_reg[c] = '0;
      ctl_reg[c] = '0;
      cur_src[c] = '0;
      cur_dst[c] = '0;
      units[c] = '0;
      run_md[c] = '0;
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < PLAN_LEN; i++)
      send(PLAN[i].op, PLAN[i].off, PLAN[i].wb, PLAN[i].ch, PLAN[i].idle);
    wait_idle();

    for (int c = 0; c < CHANNELS; c++)
      send(OP_WRITE, 6'(c * REG_BYTES + B_CTL), 8'd1, 2'(c));

    first = taken;
    while (taken - first < 400) begin
      quiet = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 6)) send_noise();
      end else begin
        program_channel($urandom_range(0, CHANNELS - 1));
      end
      if ($urandom_range(0, 30) == 0) wait_idle();
    end

    quiet = 1'b0;
    while (any_running()) step_unit();
    wait_idle();

    // start default-count runs on the last channel, then on channel 0
    quiet = 1'b1;
    for (int b = 0; b < 3; b++)
      send(OP_WRITE, 6'(BIG_COUNT_CH * REG_BYTES + B_CTL + b), 8'h00, 2'd3);
    send(OP_WRITE, 6'(BIG_COUNT_CH * REG_BYTES + CTRL_TOP_BYTE), 8'hC0, 2'd3);
    repeat (8) step_unit();
    for (int b = 0; b < 3; b++) send(OP_WRITE, 6'(B_CTL + b), 8'h00, 2'd0);
    send(OP_WRITE, 6'(CTRL_TOP_BYTE), 8'h80, 2'd0);
    repeat (8) step_unit();

    wait_idle();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && due_transfers.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/da4_pkg.sv
rtl/four_channel_dma_address_engine.sv
dv/testbench.sv
